// ===== hw/rtl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types, opcodes and the saturating sign-magnitude helper for the
// Q24.8 fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package qalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NQ_W      = DATA_W + FRAC_BITS;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GE  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_MIN = 4'd10;
    localparam logic [3:0] OP_MAX = 4'd11;
    localparam logic [3:0] OP_INC = 4'd12;
    localparam logic [3:0] OP_DEC = 4'd13;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic [3:0]        func;
        logic              neg;     // sign of the divide result
        logic              divz;
        logic [DATA_W-1:0] rem;
        logic [NQ_W-1:0]   nq;      // dividend bits shifting out, quotient bits in
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic [1:0]        st;
    } t_slot;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } t_sat;

    // Turns a magnitude and a sign into a saturated two's-complement value.
    function automatic t_sat sat_mag(input logic [63:0] mag, input logic neg);
        t_sat r;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > {32'd0, VAL_MIN}) begin
                r.val = VAL_MIN;
                r.sat = 1'b1;
            end else begin
                r.val = '0 - mag[DATA_W-1:0];
            end
        end else begin
            if (mag > {32'd0, VAL_MAX}) begin
                r.val = VAL_MAX;
                r.sat = 1'b1;
            end else begin
                r.val = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/qalu_front.sv =====
// ----------------------------------------------------------------------------
// qalu_front
// First two stages: operand decode, the simple operations, the multiplier
// and its rounding, and the start values of the divider.
// ----------------------------------------------------------------------------
module qalu_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [3:0]                     i_func,
    input  logic [qalu_pkg::DATA_W-1:0]    i_a,
    input  logic [qalu_pkg::DATA_W-1:0]    i_b,
    output logic                           o_valid,
    output qalu_pkg::t_slot                o_slot
);
    import qalu_pkg::*;

    logic               r_va;
    t_slot              r_sa;
    logic signed [63:0] r_prod;
    t_slot              n_sa;
    logic               r_vb;
    t_slot              r_sb;
    t_slot              n_sb;

    logic [DATA_W:0]    sum;
    logic [DATA_W:0]    dif;
    logic [DATA_W:0]    incv;
    logic [DATA_W:0]    decv;
    logic signed [DATA_W-1:0] sa;
    logic signed [DATA_W-1:0] sb;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;
    logic               p_neg;
    logic [63:0]        p_mag;
    logic [63:0]        p_rnd;
    t_sat               p_sat;

    function automatic t_sat clamp33(input logic [DATA_W:0] v);
        t_sat r;
        r.sat = v[DATA_W] ^ v[DATA_W-1];
        r.val = r.sat ? (v[DATA_W] ? VAL_MIN : VAL_MAX) : v[DATA_W-1:0];
        return r;
    endfunction

    assign sa    = i_a;
    assign sb    = i_b;
    assign sum   = {i_a[DATA_W-1], i_a} + {i_b[DATA_W-1], i_b};
    assign dif   = {i_a[DATA_W-1], i_a} - {i_b[DATA_W-1], i_b};
    assign incv  = {i_a[DATA_W-1], i_a} + (DATA_W+1)'(1);
    assign decv  = {i_a[DATA_W-1], i_a} - (DATA_W+1)'(1);
    assign mag_a = i_a[DATA_W-1] ? ('0 - i_a) : i_a;
    assign mag_b = i_b[DATA_W-1] ? ('0 - i_b) : i_b;

    always_comb begin
        t_sat c;
        n_sa      = '0;
        n_sa.func = i_func;
        n_sa.neg  = i_a[DATA_W-1] ^ i_b[DATA_W-1];
        n_sa.divz = (i_b == '0);
        n_sa.nq   = {mag_a, {FRAC_BITS{1'b0}}};
        n_sa.den  = mag_b;
        c         = '0;
        unique case (i_func)
            OP_ADD: c = clamp33(sum);
            OP_SUB: c = clamp33(dif);
            OP_INC: c = clamp33(incv);
            OP_DEC: c = clamp33(decv);
            OP_GT:  n_sa.cmp = (sa > sb);
            OP_LT:  n_sa.cmp = (sa < sb);
            OP_GE:  n_sa.cmp = (sa >= sb);
            OP_LE:  n_sa.cmp = (sa <= sb);
            OP_EQ:  n_sa.cmp = (sa == sb);
            OP_NE:  n_sa.cmp = (sa != sb);
            OP_MIN: c.val = (sa < sb) ? i_a : i_b;
            OP_MAX: c.val = (sa > sb) ? i_a : i_b;
            default: c = '0;
        endcase
        n_sa.res = c.val;
        n_sa.st  = c.sat ? ST_SAT : ST_OK;
    end

    // Multiply rounding: magnitude plus half an LSB, then drop the fraction.
    assign p_neg = r_prod[63];
    assign p_mag = p_neg ? (64'd0 - r_prod) : r_prod;
    assign p_rnd = (p_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign p_sat = sat_mag(p_rnd, p_neg);

    always_comb begin
        n_sb = r_sa;
        if (r_sa.func == OP_MUL) begin
            n_sb.res = p_sat.val;
            n_sb.st  = p_sat.sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa   <= n_sa;
            r_prod <= sa * sb;
            r_sb   <= n_sb;
        end
    end

    assign o_valid = r_vb;
    assign o_slot  = r_sb;

endmodule

// ===== hw/rtl/qalu_div_stage.sv =====
// ----------------------------------------------------------------------------
// qalu_div_stage
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module qalu_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  qalu_pkg::t_slot i_slot,
    output logic            o_valid,
    output qalu_pkg::t_slot o_slot
);
    import qalu_pkg::*;

    logic          r_valid;
    t_slot         r_slot;
    t_slot         n_slot;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic          qbit;

    assign trial = {i_slot.rem, i_slot.nq[NQ_W-1]};
    assign diff  = trial - {1'b0, i_slot.den};
    assign qbit  = (trial >= {1'b0, i_slot.den});

    always_comb begin
        n_slot     = i_slot;
        n_slot.rem = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        n_slot.nq  = {i_slot.nq[NQ_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slot <= n_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

// ===== hw/rtl/qalu_back.sv =====
// ----------------------------------------------------------------------------
// qalu_back
// Last stage: divide rounding and saturation, result selection and the
// output register.
// ----------------------------------------------------------------------------
module qalu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  qalu_pkg::t_slot             i_slot,
    output logic                        o_valid,
    output logic [qalu_pkg::DATA_W-1:0] o_value,
    output logic                        o_cmp,
    output logic [1:0]                  o_st
);
    import qalu_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_value;
    logic              r_cmp;
    logic [1:0]        r_st;
    logic [DATA_W-1:0] n_value;
    logic              n_cmp;
    logic [1:0]        n_st;
    logic              rnd_up;
    logic [63:0]       q;
    t_sat              q_sat;

    // Round half up on the magnitude: bump when twice the remainder reaches the divisor.
    assign rnd_up = ({i_slot.rem, 1'b0} >= {1'b0, i_slot.den});
    assign q      = {{(64-NQ_W){1'b0}}, i_slot.nq} + {63'd0, rnd_up};
    assign q_sat  = sat_mag(q, i_slot.neg);

    always_comb begin
        n_value = i_slot.res;
        n_cmp   = i_slot.cmp;
        n_st    = i_slot.st;
        if (i_slot.func == OP_DIV) begin
            n_cmp = 1'b0;
            if (i_slot.divz) begin
                n_value = '0;
                n_st    = ST_DIVZ;
            end else begin
                n_value = q_sat.val;
                n_st    = q_sat.sat ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_cmp   <= n_cmp;
            r_st    <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_cmp   = r_cmp;
    assign o_st    = r_st;

endmodule

// ===== hw/rtl/fixed_point_q24_8_alu_core.sv =====
// Pipeline from input transfer to result: two front stages, one
// divider stage per quotient bit, 40 for Q24.8, and the output register.
// Throughput: one operation per cycle; the whole pipeline advances together
// and holds while a result waits on the output.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Pipelined signed Q24.8 ALU: add, sub, mul, div, compares, min, max, inc, dec.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // func[3:0], operand_a[35:4], operand_b[67:36], zero fill
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // result_value[31:0], compare_true[32], status[34:33], zero fill
    output logic [39:0] o_m_tdata
);
    import qalu_pkg::*;

    logic              en;
    logic              v_chain [NQ_W+1];
    t_slot             s_chain [NQ_W+1];
    logic [DATA_W-1:0] value;
    logic              cmp;
    logic [1:0]        st;

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    qalu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_func  (i_s_tdata[3:0]),
        .i_a     (i_s_tdata[35:4]),
        .i_b     (i_s_tdata[67:36]),
        .o_valid (v_chain[0]),
        .o_slot  (s_chain[0])
    );

    for (genvar k = 0; k < NQ_W; k++) begin : g_div
        qalu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[k]),
            .i_slot  (s_chain[k]),
            .o_valid (v_chain[k+1]),
            .o_slot  (s_chain[k+1])
        );
    end

    qalu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_chain[NQ_W]),
        .i_slot  (s_chain[NQ_W]),
        .o_valid (o_m_tvalid),
        .o_value (value),
        .o_cmp   (cmp),
        .o_st    (st)
    );

    assign o_m_tdata = {5'd0, st, cmp, value};

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && st == ST_DIVZ) |-> (value == '0 && !cmp))
        else $error("divide by zero result not cleared");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && cmp) |-> (value == '0 && st == ST_OK))
        else $error("compare result carries value or status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (st == ST_OK || st == ST_SAT || st == ST_DIVZ))
        else $error("undefined status code");

endmodule
